### rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ARP cache and responder: field layout
// of the stream words, command and result codes, and the controller's
// command and status structures.
// ----------------------------------------------------------------------------
package arpc_pkg;

    // Default number of node table slots.
    localparam int NODE_SLOTS_DEF = 16;

    // Field widths.
    localparam int CMD_W   = 2;
    localparam int SLOTIN_W = 4;
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int IDENT_W = 16;
    localparam int OP_W    = 2;
    localparam int TAG_W   = 8;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Input tdata layout, lowest bit first.
    localparam int IN_SLOT_LSB   = 0;
    localparam int IN_NIP_LSB    = IN_SLOT_LSB + SLOTIN_W;
    localparam int IN_IDENT_LSB  = IN_NIP_LSB + IP_W;
    localparam int IN_OP_LSB     = IN_IDENT_LSB + IDENT_W;
    localparam int IN_SIP_LSB    = IN_OP_LSB + OP_W;
    localparam int IN_SMAC_LSB   = IN_SIP_LSB + IP_W;
    localparam int IN_TIP_LSB    = IN_SMAC_LSB + MAC_W;
    localparam int IN_QIP_LSB    = IN_TIP_LSB + IP_W;
    localparam int IN_QTAG_LSB   = IN_QIP_LSB + IP_W;
    localparam int IN_USED_W     = IN_QTAG_LSB + TAG_W;
    localparam int IN_DATA_W     = ((IN_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest bit first.
    localparam int OUT_DMAC_LSB  = 0;
    localparam int OUT_TIP_LSB   = OUT_DMAC_LSB + MAC_W;
    localparam int OUT_AMAC_LSB  = OUT_TIP_LSB + IP_W;
    localparam int OUT_ATAG_LSB  = OUT_AMAC_LSB + MAC_W;
    localparam int OUT_USED_W    = OUT_ATAG_LSB + TAG_W;
    localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

    localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_FRAME = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd_code;

    localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
    localparam logic [OP_W-1:0] OP_REPLY   = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_REPLY    = 2'd0,
        KIND_ANSWER   = 2'd1,
        KIND_BCAST    = 2'd2,
        KIND_RESOLVED = 2'd3
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDENT     = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY_A,
        ST_KEY_T,
        ST_KEY_L,
        ST_ENC_L,
        ST_EXEC
    } t_state;

    // Which address is driven into the compare bank.
    typedef enum logic [1:0] {
        KEY_PRIMARY,
        KEY_TARGET,
        KEY_LOCAL
    } t_key_sel;

    // Which lookup result register takes the encoded match.
    typedef enum logic [1:0] {
        ENC_NONE,
        ENC_PRIMARY,
        ENC_TARGET,
        ENC_LOCAL
    } t_enc_dst;

    typedef struct packed {
        logic     capture;
        t_key_sel key_sel;
        t_enc_dst enc_dst;
        logic     load_wr;
        logic     commit;
    } t_ctl_cmd;

    typedef struct packed {
        t_cmd_code cmd;
        logic      emit;
        logic      out_free;
    } t_dp_status;

endpackage

### rtl/arpc_ctrl.sv
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer for the ARP cache: steps each frame or query through the three
// address lookups and the final commit, holding a commit with a result while
// the result register is still occupied; a load only writes its slot.
// ----------------------------------------------------------------------------
module arpc_ctrl
    import arpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  t_dp_status i_status,
    output t_ctl_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_s_tready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.key_sel = KEY_PRIMARY;
        o_cmd.enc_dst = ENC_NONE;
        o_cmd.load_wr = 1'b0;
        o_cmd.commit  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_KEY_A;
                end
            end
            ST_KEY_A: begin
                o_cmd.key_sel = KEY_PRIMARY;
                unique case (i_status.cmd)
                    CMD_LOAD: begin
                        o_cmd.load_wr = 1'b1;
                        n_state       = ST_IDLE;
                    end
                    CMD_NONE:  n_state = ST_IDLE;
                    CMD_FRAME: n_state = ST_KEY_T;
                    CMD_QUERY: n_state = ST_KEY_T;
                    default:   n_state = ST_IDLE;
                endcase
            end
            ST_KEY_T: begin
                o_cmd.key_sel = KEY_TARGET;
                o_cmd.enc_dst = ENC_PRIMARY;
                n_state       = ST_KEY_L;
            end
            ST_KEY_L: begin
                o_cmd.key_sel = KEY_LOCAL;
                o_cmd.enc_dst = ENC_TARGET;
                n_state       = ST_ENC_L;
            end
            ST_ENC_L: begin
                o_cmd.enc_dst = ENC_LOCAL;
                n_state       = ST_EXEC;
            end
            ST_EXEC: begin
                if (!i_status.emit || i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

### rtl/arpc_datapath.sv
// ----------------------------------------------------------------------------
// arpc_datapath
// Node table with its compare bank, per-slot flags, MAC and requester
// memories, configuration registers and the result register.
// ----------------------------------------------------------------------------
module arpc_datapath
    import arpc_pkg::*;
#(
    parameter int NODE_SLOTS = NODE_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic [CMD_W-1:0]      i_s_tuser,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [MAC_W-1:0]      i_cfg_data,
    input  t_ctl_cmd              i_cmd,
    output t_dp_status            o_status,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic [KIND_W-1:0]     o_m_tuser
);

    localparam int SLOT_W = $clog2(NODE_SLOTS);
    localparam int WIDE_W = 7;

    // Captured request fields.
    t_cmd_code            r_cmd;
    logic [SLOTIN_W-1:0]  r_node_slot;
    logic [IP_W-1:0]      r_node_ip;
    logic [IDENT_W-1:0]   r_frame_ident;
    logic [OP_W-1:0]      r_frame_op;
    logic [IP_W-1:0]      r_src_ip;
    logic [MAC_W-1:0]     r_src_mac;
    logic [IP_W-1:0]      r_dst_ip;
    logic [IP_W-1:0]      r_query_ip;
    logic [TAG_W-1:0]     r_query_tag;

    // Configuration.
    logic [IP_W-1:0]      r_local_ip;
    logic [IDENT_W-1:0]   r_ident_value;

    // Node table and flags.
    logic [IP_W-1:0]      r_node_tab [NODE_SLOTS];
    logic [NODE_SLOTS-1:0] r_loaded;
    logic [NODE_SLOTS-1:0] r_valid;
    logic [NODE_SLOTS-1:0] r_waiting;

    // MAC and requester memories.
    logic [MAC_W-1:0]     r_mac_mem [NODE_SLOTS];
    logic [TAG_W-1:0]     r_req_mem [NODE_SLOTS];
    logic [MAC_W-1:0]     r_mac_rd;
    logic [TAG_W-1:0]     r_req_rd;

    // Lookup pipeline.
    logic [NODE_SLOTS-1:0] r_match;
    logic [IP_W-1:0]      key;
    logic                 enc_hit;
    logic [SLOT_W-1:0]    enc_idx;
    logic                 r_ahit, r_thit, r_lhit;
    logic [SLOT_W-1:0]    r_aidx, r_tidx, r_lidx;

    // Result register.
    logic                 r_out_valid;
    t_kind                r_out_kind;
    logic [MAC_W-1:0]     r_out_dmac;
    logic [IP_W-1:0]      r_out_tip;
    logic [MAC_W-1:0]     r_out_amac;
    logic [TAG_W-1:0]     r_out_atag;

    // Decision terms.
    logic                 ident_ok, frame_ok, is_req, is_rep, for_us;
    logic                 is_query, cur_valid, cur_wait;
    logic                 set_valid, mac_we, q_miss, emit;
    t_kind                kind;
    logic [MAC_W-1:0]     dmac, amac;
    logic [IP_W-1:0]      tip;
    logic [TAG_W-1:0]     atag;
    logic [WIDE_W-1:0]    slot_wide;
    logic                 slot_ok;
    logic [SLOT_W-1:0]    load_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd         <= t_cmd_code'(i_s_tuser);
            r_node_slot   <= i_s_tdata[IN_SLOT_LSB +: SLOTIN_W];
            r_node_ip     <= i_s_tdata[IN_NIP_LSB +: IP_W];
            r_frame_ident <= i_s_tdata[IN_IDENT_LSB +: IDENT_W];
            r_frame_op    <= i_s_tdata[IN_OP_LSB +: OP_W];
            r_src_ip      <= i_s_tdata[IN_SIP_LSB +: IP_W];
            r_src_mac     <= i_s_tdata[IN_SMAC_LSB +: MAC_W];
            r_dst_ip      <= i_s_tdata[IN_TIP_LSB +: IP_W];
            r_query_ip    <= i_s_tdata[IN_QIP_LSB +: IP_W];
            r_query_tag   <= i_s_tdata[IN_QTAG_LSB +: TAG_W];
        end
    end

    // The local MAC only goes into frame encoding, which happens downstream,
    // so index one is accepted and has no effect here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip    <= '0;
            r_ident_value <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_LOCAL_IP) begin
                r_local_ip <= i_cfg_data[IP_W-1:0];
            end
            if (i_cfg_index == CFG_IDENT) begin
                r_ident_value <= i_cfg_data[IDENT_W-1:0];
            end
        end
    end

    // Compare bank: one comparator per slot, key chosen by the sequencer.
    always_comb begin
        unique case (i_cmd.key_sel)
            KEY_PRIMARY: key = (r_cmd == CMD_QUERY) ? r_query_ip : r_src_ip;
            KEY_TARGET:  key = r_dst_ip;
            KEY_LOCAL:   key = r_local_ip;
            default:     key = r_src_ip;
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NODE_SLOTS; i++) begin
            r_match[i] <= r_loaded[i] && (r_node_tab[i] == key);
        end
    end

    // Lowest matching slot wins.
    always_comb begin
        enc_hit = 1'b0;
        enc_idx = '0;
        for (int i = NODE_SLOTS - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                enc_hit = 1'b1;
                enc_idx = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.enc_dst)
            ENC_PRIMARY: begin
                r_ahit <= enc_hit;
                r_aidx <= enc_idx;
            end
            ENC_TARGET: begin
                r_thit <= enc_hit;
                r_tidx <= enc_idx;
            end
            ENC_LOCAL: begin
                r_lhit <= enc_hit;
                r_lidx <= enc_idx;
            end
            default: ;
        endcase
    end

    // Decision for the commit step.
    always_comb begin
        ident_ok  = (r_frame_ident == r_ident_value);
        frame_ok  = (r_cmd == CMD_FRAME) && ident_ok && r_ahit;
        is_req    = frame_ok && (r_frame_op == OP_REQUEST);
        is_rep    = frame_ok && (r_frame_op == OP_REPLY);
        for_us    = r_thit && r_lhit && (r_tidx == r_lidx);
        is_query  = (r_cmd == CMD_QUERY) && r_ahit;
        cur_valid = r_valid[r_aidx];
        cur_wait  = r_waiting[r_aidx];
        set_valid = (is_req && for_us) || (is_rep && cur_wait);
        mac_we    = set_valid || (is_req && cur_valid);
        q_miss    = is_query && !cur_valid;
        emit      = set_valid || is_query;

        kind = KIND_REPLY;
        dmac = '0;
        tip  = '0;
        amac = '0;
        atag = '0;
        priority if (is_req) begin
            kind = KIND_REPLY;
            dmac = r_src_mac;
            tip  = r_src_ip;
        end else if (is_rep) begin
            kind = KIND_RESOLVED;
            amac = r_src_mac;
            atag = r_req_rd;
        end else if (cur_valid) begin
            kind = KIND_ANSWER;
            amac = r_mac_rd;
            atag = r_query_tag;
        end else begin
            kind = KIND_BCAST;
            dmac = MAC_BCAST;
            tip  = r_query_ip;
        end
    end

    assign slot_wide = {{(WIDE_W - SLOTIN_W){1'b0}}, r_node_slot};
    assign slot_ok   = slot_wide < WIDE_W'(NODE_SLOTS);
    assign load_idx  = slot_wide[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded  <= '0;
            r_valid   <= '0;
            r_waiting <= '0;
        end else if (i_cmd.load_wr && slot_ok) begin
            r_loaded[load_idx]  <= 1'b1;
            r_valid[load_idx]   <= 1'b0;
            r_waiting[load_idx] <= 1'b0;
        end else if (i_cmd.commit) begin
            if (set_valid) begin
                r_valid[r_aidx] <= 1'b1;
            end
            if (is_rep && cur_wait) begin
                r_waiting[r_aidx] <= 1'b0;
            end
            if (q_miss) begin
                r_waiting[r_aidx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && slot_ok) begin
            r_node_tab[load_idx] <= r_node_ip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && mac_we) begin
            r_mac_mem[r_aidx] <= r_src_mac;
        end
        r_mac_rd <= r_mac_mem[r_aidx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && q_miss) begin
            r_req_mem[r_aidx] <= r_query_tag;
        end
        r_req_rd <= r_req_mem[r_aidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && emit) begin
            r_out_kind <= kind;
            r_out_dmac <= dmac;
            r_out_tip  <= tip;
            r_out_amac <= amac;
            r_out_atag <= atag;
        end
    end

    assign o_status.cmd      = r_cmd;
    assign o_status.emit     = emit;
    assign o_status.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}},
                         r_out_atag, r_out_amac, r_out_tip, r_out_dmac};

endmodule

### rtl/arp_cache_responder.sv
// ----------------------------------------------------------------------------
// arp_cache_responder
// ARP cache and responder over a fixed node table, with stream input and
// output channels and a register write channel.
// ----------------------------------------------------------------------------
// One request is handled at a time. A frame or a local query goes from
// acceptance to the moment its result, if any, enters the output register
// through three address lookups (sender or query address, target address,
// local address) that share one compare bank across all node slots, each
// followed by a registered lowest-slot encoder, and a final commit step that
// updates the flags and memories. A load request only writes its slot. The
// commit step of a request with a result waits while the output register
// still holds an untaken result, so a new request is accepted while a
// finished result is waiting downstream. The node table, MAC and requester
// memories have no reset pass; per-slot loaded, valid and waiting flags are
// cleared by reset and decide whether a stored entry is ever looked at. The
// user must write registers through the configuration channel only while no
// request is in progress; the block does not enforce it. The local MAC
// register is accepted but not used, as frames are built downstream.
// ----------------------------------------------------------------------------
module arp_cache_responder
    import arpc_pkg::*;
#(
    parameter int NODE_SLOTS = NODE_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request channel.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tdata, from bit 0 up: node_slot(4), node_ip(32), frame_ident(16),
    // frame_op(2), src_ip(32), src_mac(48), dst_ip(32),
    // query_ip(32), query_tag(8), two zero pad bits.
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // tuser: cmd(2).
    input  logic [CMD_W-1:0]      s_tuser,
    // Result channel.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tdata, from bit 0 up: dest_mac(48), frame_dst_ip(32),
    // answer_mac(48), answer_tag(8).
    output logic [OUT_DATA_W-1:0] m_tdata,
    // tuser: kind(2).
    output logic [KIND_W-1:0]     m_tuser,
    // Register write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [MAC_W-1:0]      i_cfg_data
);

    t_ctl_cmd   ctl_cmd;
    t_dp_status dp_status;

    // Register writes are always accepted.
    assign o_cfg_ready = 1'b1;

    arpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_status   (dp_status),
        .o_cmd      (ctl_cmd)
    );

    arpc_datapath #(
        .NODE_SLOTS (NODE_SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (ctl_cmd),
        .o_status    (dp_status),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

endmodule

### rtl/arpc_checker.sv
// ----------------------------------------------------------------------------
// arpc_checker
// Port-level checks for the ARP cache and responder, bound to the top level.
// ----------------------------------------------------------------------------
module arpc_checker
    import arpc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [KIND_W-1:0]     m_tuser
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Only one request is in progress: acceptance closes the input.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in progress");

    // A broadcast request goes to the all-ones MAC.
    a_bcast_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser == KIND_BCAST) |->
        m_tdata[OUT_DMAC_LSB +: MAC_W] == MAC_BCAST)
        else $error("broadcast without all-ones destination");

    // Client answers carry no frame addressing.
    a_answer_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && ((m_tuser == KIND_ANSWER) || (m_tuser == KIND_RESOLVED)) |->
        m_tdata[OUT_AMAC_LSB-1:0] == '0)
        else $error("client answer carries frame fields");

endmodule

bind arp_cache_responder arpc_checker u_arpc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ARP cache and responder. Requests are sent on
// the stream input with random idling on both sides. A scoreboard model of
// the node table and the cache flags predicts each result, and every result
// leaving the block is compared, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import arpc_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 12;
    // This margin covers a request that gives no result and is still in flight
    // when the last awaited result arrives.
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 20000;
    localparam int POOL_SIZE     = 12;

    // Operation codes that the block must drop as unknown.
    localparam logic [OP_W-1:0] OP_UNUSED_LOW  = 2'd0;
    localparam logic [OP_W-1:0] OP_UNUSED_HIGH = 2'd3;

    typedef struct packed {
        t_cmd_code           cmd;
        logic [SLOTIN_W-1:0] slot;
        logic [IP_W-1:0]     node_ip;
        logic [IDENT_W-1:0]  ident;
        logic [OP_W-1:0]     op;
        logic [IP_W-1:0]     src_ip;
        logic [MAC_W-1:0]    src_mac;
        logic [IP_W-1:0]     dst_ip;
        logic [IP_W-1:0]     query_ip;
        logic [TAG_W-1:0]    query_tag;
    } arp_request_t;

    typedef struct packed {
        t_kind            kind;
        logic [MAC_W-1:0] dest_mac;
        logic [IP_W-1:0]  dst_ip;
        logic [MAC_W-1:0] answer_mac;
        logic [TAG_W-1:0] answer_tag;
    } arp_result_t;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    // tdata, from bit 0 up: node_slot, node_ip, frame_ident, frame_op,
    // src_ip, src_mac, dst_ip, query_ip, query_tag, zero padding.
    logic [IN_DATA_W-1:0]  s_tdata     = '0;
    // tuser: cmd.
    logic [CMD_W-1:0]      s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    // tdata, from bit 0 up: dest_mac, frame_dst_ip, answer_mac, answer_tag.
    logic [OUT_DATA_W-1:0] m_tdata;
    // tuser: kind.
    logic [KIND_W-1:0]     m_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [MAC_W-1:0]      i_cfg_data  = '0;

    // Scoreboard copy of the registers and of the node table.
    logic [IP_W-1:0]    cfg_local_ip;
    logic [MAC_W-1:0]   cfg_local_mac;
    logic [IDENT_W-1:0] cfg_ident;
    logic [IP_W-1:0]    node_table      [NODE_SLOTS_DEF];
    logic               node_loaded     [NODE_SLOTS_DEF];
    logic [MAC_W-1:0]   entry_mac       [NODE_SLOTS_DEF];
    logic               entry_valid     [NODE_SLOTS_DEF];
    logic               entry_waiting   [NODE_SLOTS_DEF];
    logic [TAG_W-1:0]   entry_requester [NODE_SLOTS_DEF];

    arp_result_t awaited_responses[$];
    logic [IP_W-1:0] ip_pool[POOL_SIZE];

    int fail_count = 0;
    int request_count[4];
    int result_count[4];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Long output hold-off: the main sequence bumps the sequence number and
    // the receiver process counts the stall down on its own.
    int holdoff_len  = 0;
    int holdoff_seq  = 0;
    int holdoff_seen = 0;
    int holdoff_left = 0;

    arp_cache_responder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Lowest loaded slot holding the address, or -1 when none does.
    function automatic int lookup_slot(input logic [IP_W-1:0] ip);
        for (int s = 0; s < NODE_SLOTS_DEF; s++) begin
            if (node_loaded[s] && node_table[s] == ip)
                return s;
        end
        return -1;
    endfunction

    // Applies one accepted request to the scoreboard state and queues the
    // result that it must cause, if any.
    task automatic predict_arp_response(input arp_request_t req);
        arp_result_t res;
        int          peer;
        int          target_slot;
        int          local_slot;
        res = '0;
        case (req.cmd)
            CMD_LOAD: begin
                if (int'(req.slot) < NODE_SLOTS_DEF) begin
                    node_table[req.slot]    = req.node_ip;
                    node_loaded[req.slot]   = 1'b1;
                    entry_valid[req.slot]   = 1'b0;
                    entry_waiting[req.slot] = 1'b0;
                end
            end
            CMD_FRAME: begin
                peer = lookup_slot(req.src_ip);
                if (req.ident == cfg_ident && peer >= 0) begin
                    if (req.op == OP_REQUEST) begin
                        target_slot = lookup_slot(req.dst_ip);
                        local_slot  = lookup_slot(cfg_local_ip);
                        if (target_slot >= 0 && target_slot == local_slot) begin
                            // Aimed at us: learn the sender and answer it.
                            entry_mac[peer]   = req.src_mac;
                            entry_valid[peer] = 1'b1;
                            res.kind     = KIND_REPLY;
                            res.dest_mac = req.src_mac;
                            res.dst_ip   = req.src_ip;
                            awaited_responses.push_back(res);
                        end else if (entry_valid[peer]) begin
                            entry_mac[peer] = req.src_mac;
                        end
                    end else if (req.op == OP_REPLY && entry_waiting[peer]) begin
                        entry_mac[peer]     = req.src_mac;
                        entry_waiting[peer] = 1'b0;
                        entry_valid[peer]   = 1'b1;
                        res.kind       = KIND_RESOLVED;
                        res.answer_mac = req.src_mac;
                        res.answer_tag = entry_requester[peer];
                        awaited_responses.push_back(res);
                    end
                end
            end
            CMD_QUERY: begin
                peer = lookup_slot(req.query_ip);
                if (peer >= 0) begin
                    if (entry_valid[peer]) begin
                        res.kind       = KIND_ANSWER;
                        res.answer_mac = entry_mac[peer];
                        res.answer_tag = req.query_tag;
                    end else begin
                        entry_requester[peer] = req.query_tag;
                        entry_waiting[peer]   = 1'b1;
                        res.kind     = KIND_BCAST;
                        res.dest_mac = MAC_BCAST;
                        res.dst_ip   = req.query_ip;
                    end
                    awaited_responses.push_back(res);
                end
            end
            default: ;
        endcase
    endtask

    function automatic logic [IN_DATA_W-1:0] pack_request(input arp_request_t r);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[IN_SLOT_LSB  +: SLOTIN_W] = r.slot;
        d[IN_NIP_LSB   +: IP_W]     = r.node_ip;
        d[IN_IDENT_LSB +: IDENT_W]  = r.ident;
        d[IN_OP_LSB    +: OP_W]     = r.op;
        d[IN_SIP_LSB   +: IP_W]     = r.src_ip;
        d[IN_SMAC_LSB  +: MAC_W]    = r.src_mac;
        d[IN_TIP_LSB   +: IP_W]     = r.dst_ip;
        d[IN_QIP_LSB   +: IP_W]     = r.query_ip;
        d[IN_QTAG_LSB  +: TAG_W]    = r.query_tag;
        return d;
    endfunction

    // Every field random; the request builders below overwrite what matters.
    function automatic arp_request_t random_fields();
        arp_request_t r;
        r.cmd       = t_cmd_code'($urandom_range(3));
        r.slot      = SLOTIN_W'($urandom());
        r.node_ip   = $urandom();
        r.ident     = IDENT_W'($urandom());
        r.op        = OP_W'($urandom());
        r.src_ip    = $urandom();
        r.src_mac   = {16'($urandom()), $urandom()};
        r.dst_ip    = $urandom();
        r.query_ip  = $urandom();
        r.query_tag = TAG_W'($urandom());
        return r;
    endfunction

    function automatic arp_request_t make_load(input logic [SLOTIN_W-1:0] slot,
                                               input logic [IP_W-1:0] ip);
        arp_request_t r;
        r         = random_fields();
        r.cmd     = CMD_LOAD;
        r.slot    = slot;
        r.node_ip = ip;
        return r;
    endfunction

    function automatic arp_request_t make_frame(input logic [IDENT_W-1:0] ident,
                                                input logic [OP_W-1:0] op,
                                                input logic [IP_W-1:0] sip,
                                                input logic [MAC_W-1:0] smac,
                                                input logic [IP_W-1:0] tip);
        arp_request_t r;
        r         = random_fields();
        r.cmd     = CMD_FRAME;
        r.ident   = ident;
        r.op      = op;
        r.src_ip  = sip;
        r.src_mac = smac;
        r.dst_ip  = tip;
        return r;
    endfunction

    function automatic arp_request_t make_query(input logic [IP_W-1:0] ip,
                                                input logic [TAG_W-1:0] tag);
        arp_request_t r;
        r           = random_fields();
        r.cmd       = CMD_QUERY;
        r.query_ip  = ip;
        r.query_tag = tag;
        return r;
    endfunction

    function automatic logic [IP_W-1:0] pool_ip();
        return ip_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    // Random traffic drawn mostly from a small address pool, so that loads,
    // queries, requests and replies keep meeting the same slots and the
    // waiting and resolved paths are reached often.
    function automatic arp_request_t random_request();
        arp_request_t r;
        int           pick;
        r    = random_fields();
        pick = $urandom_range(99);
        if (pick < 15)
            r.cmd = CMD_LOAD;
        else if (pick < 57)
            r.cmd = CMD_FRAME;
        else if (pick < 95)
            r.cmd = CMD_QUERY;
        else
            r.cmd = CMD_NONE;
        if ($urandom_range(9) != 0)
            r.node_ip = pool_ip();
        if ($urandom_range(7) != 0)
            r.ident = cfg_ident;
        // About one frame in ten keeps its random operation, half the time unknown.
        pick = $urandom_range(19);
        if (pick < 10)
            r.op = OP_REQUEST;
        else if (pick < 18)
            r.op = OP_REPLY;
        if ($urandom_range(9) != 0)
            r.src_ip = pool_ip();
        pick = $urandom_range(9);
        if (pick < 5)
            r.dst_ip = cfg_local_ip;
        else if (pick < 9)
            r.dst_ip = pool_ip();
        if ($urandom_range(9) != 0)
            r.query_ip = pool_ip();
        pick = $urandom_range(19);
        if (pick == 0)
            r.src_mac = '0;
        else if (pick == 1)
            r.src_mac = '1;
        return r;
    endfunction

    // Offers one request, sometimes after a random gap, and holds it until
    // accepted. The valid is left high so that back-to-back requests need no
    // second assignment in the same step.
    task automatic send_request(input arp_request_t req);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.cmd;
        s_tdata  <= pack_request(req);
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_arp_response(req);
        request_count[req.cmd]++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [MAC_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_LOCAL_IP:  cfg_local_ip  = value[IP_W-1:0];
            CFG_LOCAL_MAC: cfg_local_mac = value;
            CFG_IDENT:     cfg_ident     = value[IDENT_W-1:0];
            default: ;
        endcase
    endtask

    // Only called while the block is idle.
    task automatic configure(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac,
                             input logic [IDENT_W-1:0] ident);
        write_register(CFG_LOCAL_IP, MAC_W'(ip));
        write_register(CFG_LOCAL_MAC, mac);
        write_register(CFG_IDENT, MAC_W'(ident));
        i_cfg_valid <= 1'b0;
    endtask

    // Stops offering and waits until every predicted result has arrived and
    // any request without a result has had time to finish.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (awaited_responses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    localparam logic [IP_W-1:0]    HOME_IP  = 32'h0A00_0001;
    localparam logic [IP_W-1:0]    PEER_IP  = 32'hC0A8_0002;
    localparam logic [IDENT_W-1:0] HOME_TAG = 16'hBEEF;

    // Table loading and the reasons a frame is dropped, ending with a first
    // reply to a request aimed at this node and a query answered from the cache.
    task automatic test_frame_filtering();
        configure(HOME_IP, 48'h0200_0000_0001, HOME_TAG);
        // Nothing is loaded yet, so neither of these can match.
        send_request(make_query(32'hFFFF_FFFF, 8'h11));
        send_request(make_frame(HOME_TAG, OP_REQUEST, 32'hFFFF_FFFF, 48'h1, HOME_IP));
        send_request(make_load(4'd15, 32'hFFFF_FFFF));
        // Sender known but this node's own address is not in the table yet.
        send_request(make_frame(HOME_TAG, OP_REQUEST, 32'hFFFF_FFFF, 48'h2, HOME_IP));
        send_request(make_load(4'd0, HOME_IP));
        send_request(make_load(4'd1, 32'h0000_0000));
        // The same address in two slots: the lower slot must win.
        send_request(make_load(4'd2, PEER_IP));
        send_request(make_load(4'd3, PEER_IP));
        begin : unknown_cmd
            arp_request_t r;
            r     = random_fields();
            r.cmd = CMD_NONE;
            send_request(r);
        end
        send_request(make_frame(~HOME_TAG, OP_REQUEST, PEER_IP, 48'h3, HOME_IP));
        send_request(make_frame(HOME_TAG, OP_UNUSED_LOW, PEER_IP, 48'h4, HOME_IP));
        send_request(make_frame(HOME_TAG, OP_UNUSED_HIGH, PEER_IP, 48'h5, HOME_IP));
        send_request(make_frame(HOME_TAG, OP_REQUEST, PEER_IP, '1, HOME_IP));
        send_request(make_query(PEER_IP, 8'hFF));
        wait_for_drain();
    endtask

    // Misses, repeated misses, replies with and without a waiting slot,
    // refresh of a known sender and the effect of reloading a slot.
    task automatic test_query_resolution();
        // Request elsewhere from an unresolved sender: no refresh.
        send_request(make_frame(HOME_TAG, OP_REQUEST, 32'h0, 48'hA, PEER_IP));
        send_request(make_query(32'h0, 8'h00));
        // A second miss while waiting replaces the stored requester.
        send_request(make_query(32'h0, 8'h5A));
        send_request(make_frame(HOME_TAG, OP_REPLY, 32'h0, '0, HOME_IP));
        send_request(make_frame(HOME_TAG, OP_REPLY, 32'h0, 48'hB, HOME_IP));
        // Known sender asking for another host refreshes its MAC quietly.
        send_request(make_frame(HOME_TAG, OP_REQUEST, PEER_IP, 48'hDEAD_BEEF_0001,
                                32'hFFFF_FFFF));
        send_request(make_query(PEER_IP, 8'h01));
        send_request(make_load(4'd2, PEER_IP));
        send_request(make_query(PEER_IP, 8'h33));
        // A request to us while the slot waits leaves it waiting.
        send_request(make_frame(HOME_TAG, OP_REQUEST, PEER_IP, 48'h8000_0000_0000, HOME_IP));
        send_request(make_frame(HOME_TAG, OP_REPLY, PEER_IP, 48'h7FFF_FFFF_FFFF, HOME_IP));
        send_request(make_frame(HOME_TAG, OP_REPLY, 32'h1234_5678, 48'hC, HOME_IP));
        wait_for_drain();
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int count, input logic [IP_W-1:0] ip,
                                       input logic [MAC_W-1:0] mac,
                                       input logic [IDENT_W-1:0] ident);
        configure(ip, mac, ident);
        ip_pool[0] = cfg_local_ip;
        ip_pool[1] = '0;
        ip_pool[2] = '1;
        for (int i = 3; i < POOL_SIZE; i++)
            ip_pool[i] = $urandom();
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        repeat (count) send_request(random_request());
        wait_for_drain();
    endtask

    // The receiver stops for a long stretch while requests keep coming, so
    // the output register fills and the input must stall.
    task automatic test_output_backpressure();
        logic [IP_W-1:0] addr[4];
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 4; i++) begin
            addr[i] = $urandom();
            send_request(make_load(SLOTIN_W'(i), addr[i]));
        end
        holdoff_len = 400;
        holdoff_seq <= holdoff_seq + 1;
        repeat (30) send_request(make_query(addr[$urandom_range(3)], TAG_W'($urandom())));
        wait_for_drain();
    endtask

    always @(posedge i_clk) begin
        if (holdoff_seq != holdoff_seen) begin
            holdoff_seen = holdoff_seq;
            holdoff_left = holdoff_len;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_checker
        arp_result_t want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (awaited_responses.size() == 0) begin
                $display("%0t: unexpected result, expected none, got kind %0d data %h",
                         $time, m_tuser, m_tdata);
                fail_count++;
            end else begin
                want = awaited_responses.pop_front();
                compare_field("kind", 64'(want.kind), 64'(m_tuser));
                compare_field("dest_mac", 64'(want.dest_mac),
                              64'(m_tdata[OUT_DMAC_LSB +: MAC_W]));
                compare_field("frame_dst_ip", 64'(want.dst_ip),
                              64'(m_tdata[OUT_TIP_LSB +: IP_W]));
                compare_field("answer_mac", 64'(want.answer_mac),
                              64'(m_tdata[OUT_AMAC_LSB +: MAC_W]));
                compare_field("answer_tag", 64'(want.answer_tag),
                              64'(m_tdata[OUT_ATAG_LSB +: TAG_W]));
                result_count[want.kind]++;
            end
        end
    end

    // Ends the run when no handshake of any kind has happened for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        for (int s = 0; s < NODE_SLOTS_DEF; s++) begin
            node_loaded[s]   = 1'b0;
            entry_valid[s]   = 1'b0;
            entry_waiting[s] = 1'b0;
        end
        for (int k = 0; k < 4; k++) begin
            request_count[k] = 0;
            result_count[k]  = 0;
        end
        cfg_local_ip  = '0;
        cfg_local_mac = '0;
        cfg_ident     = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_frame_filtering();
        test_query_resolution();
        test_random_traffic(10, 53, 260, $urandom(), {16'($urandom()), $urandom()},
                            IDENT_W'($urandom()));
        test_random_traffic(53, 10, 260, '1, '1, '1);
        test_random_traffic(0, 0, 260, '0, '0, '0);
        test_output_backpressure();

        fail_count += awaited_responses.size();
        $display("Covered %0d loads, %0d frames, %0d queries, %0d unknown commands.",
                 request_count[CMD_LOAD], request_count[CMD_FRAME],
                 request_count[CMD_QUERY], request_count[CMD_NONE]);
        $display("Checked %0d replies, %0d cache answers, %0d broadcasts, %0d resolved.",
                 result_count[KIND_REPLY], result_count[KIND_ANSWER],
                 result_count[KIND_BCAST], result_count[KIND_RESOLVED]);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
